>>> rtl/core/sepq_pkg.sv
// Sorted event priority queue: shared types and codes.
// Request and response payload structs, opcodes, status codes, cell control.
// No dependencies.
package sepq_pkg;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic       op;
		logic [9:0] event_day;
		logic       event_kind;
	} sepq_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] popped_day;
		logic       popped_kind;
		logic [4:0] occupancy;
	} sepq_rsp_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} sepq_ctrl_t;

endpackage

>>> rtl/core/sepq_cell.sv
// One slot of the sorted queue chain: holds a day and a kind.
// Compares its day with the incoming one and shifts toward either neighbor.
// Depends on sepq_pkg.
module sepq_cell
	import sepq_pkg::*;
#(
	parameter int DAY_BITS = 10
) (
	input  logic                clk,
	input  sepq_ctrl_t          ctrl,
	input  logic                occ,
	input  logic [DAY_BITS-1:0] new_day,
	input  logic                new_kind,
	input  logic                prev_take,
	input  logic [DAY_BITS-1:0] prev_day,
	input  logic                prev_kind,
	input  logic [DAY_BITS-1:0] next_day,
	input  logic                next_kind,
	output logic                take,
	output logic [DAY_BITS-1:0] day,
	output logic                kind
);

	logic [DAY_BITS-1:0] day_q;
	logic                kind_q;

	// a slot at or after the insert point takes part in the shift
	assign take = !occ || (day_q > new_day);
	assign day  = day_q;
	assign kind = kind_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq && take) begin
			day_q  <= prev_take ? prev_day : new_day;
			kind_q <= prev_take ? prev_kind : new_kind;
		end else if (ctrl.deq) begin
			day_q  <= next_day;
			kind_q <= next_kind;
		end
	end

endmodule

>>> rtl/core/sorted_event_priority_queue_unit.sv
// Sorted event priority queue: a chain of QUEUE_DEPTH slot cells, head first.
// The response is registered when the request is accepted.
// One request per cycle unless rsp_ready stalls; all cells compare and shift at once.
// Reset: arst_n clears the fill count and the response valid; slot contents
// stay unknown until written and are never read before that.
module sorted_event_priority_queue_unit
	import sepq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int DAY_BITS    = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  sepq_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output sepq_rsp_t rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]    count_q;
	logic                rsp_valid_q;
	sepq_rsp_t           rsp_q;

	logic                fire;
	logic                full;
	logic                empty;
	sepq_ctrl_t          ctrl;
	logic [31:0]         day_in_ext;
	logic [DAY_BITS-1:0] new_day;
	logic [CNT_W-1:0]    count_nxt;
	logic [31:0]         count_ext;
	logic [31:0]         head_ext;
	sepq_rsp_t           rsp_d;

	logic [QUEUE_DEPTH-1:0] occ;
	logic [QUEUE_DEPTH:0]   take_w;
	logic [DAY_BITS-1:0]    day_w  [0:QUEUE_DEPTH+1];
	logic                   kind_w [0:QUEUE_DEPTH+1];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign fire      = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign ctrl.enq  = fire && (req.op == OP_ENQ) && !full;
	assign ctrl.deq  = fire && (req.op == OP_DEQ) && !empty;

	assign day_in_ext = 32'(req.event_day);
	assign new_day    = day_in_ext[DAY_BITS-1:0];

	assign take_w[0]             = 1'b0;
	assign day_w[0]              = '0;
	assign kind_w[0]             = 1'b0;
	assign day_w[QUEUE_DEPTH+1]  = '0;
	assign kind_w[QUEUE_DEPTH+1] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign occ[i] = CNT_W'(i) < count_q;

		sepq_cell #(
			.DAY_BITS (DAY_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ[i]),
			.new_day   (new_day),
			.new_kind  (req.event_kind),
			.prev_take (take_w[i]),
			.prev_day  (day_w[i]),
			.prev_kind (kind_w[i]),
			.next_day  (day_w[i+2]),
			.next_kind (kind_w[i+2]),
			.take      (take_w[i+1]),
			.day       (day_w[i+1]),
			.kind      (kind_w[i+1])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (ctrl.enq) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.deq) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign count_ext = 32'(count_nxt);
	assign head_ext  = 32'(day_w[1]);

	always_comb begin
		rsp_d             = '0;
		rsp_d.occupancy   = count_ext[4:0];
		if (req.op == OP_ENQ) begin
			rsp_d.status = full ? ST_FULL : ST_OK;
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.status      = ST_OK;
			rsp_d.popped_day  = head_ext[9:0];
			rsp_d.popped_kind = kind_w[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (req_ready) begin
				rsp_valid_q <= req_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("fill count above queue depth");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("enqueue did not advance fill count");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.deq |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("dequeue did not drop fill count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> day_w[1] <= day_w[2])
		else $error("head slot out of order");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("accepted request gave no response");
`endif

endmodule

>>> verif/tb_sorted_event_priority_queue_unit.sv
// Testbench for sorted_event_priority_queue_unit: random and directed enqueue/dequeue
// traffic with bursty idling on both channels, checked against a behavioral queue model.
// Depends on sepq_pkg and the sorted_event_priority_queue_unit RTL.
`timescale 1ns / 1ps

module tb_sorted_event_priority_queue_unit;
	import sepq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int DAY_BITS    = 10;
	localparam int CALM_TAIL   = 100;

	typedef struct packed {
		logic [9:0] day;
		logic       kind;
	} held_event_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	sepq_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	sepq_rsp_t rsp;

	sepq_req_t   request_backlog[$];
	sepq_rsp_t   responses_due[$];
	held_event_t held_events[$];

	int unsigned req_total = 0;
	int unsigned req_sent = 0;
	int unsigned req_done = 0;
	int unsigned rsp_seen = 0;
	int unsigned mismatches = 0;
	int unsigned req_gap = 0;
	int unsigned rsp_gap = 0;
	int unsigned req_idle_level = 1;
	int unsigned rsp_idle_level = 1;

	sorted_event_priority_queue_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.DAY_BITS   (DAY_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	function automatic void push_enqueue(input logic [9:0] day, input logic kind);
		sepq_req_t r;
		r.op = OP_ENQ;
		r.event_day = day;
		r.event_kind = kind;
		request_backlog.push_back(r);
	endfunction

	function automatic void push_dequeue();
		sepq_req_t r;
		r.op = OP_DEQ;
		r.event_day = 10'($urandom_range(0, 1023));
		r.event_kind = 1'($urandom_range(0, 1));
		request_backlog.push_back(r);
	endfunction

	function automatic logic [9:0] pick_day();
		case ($urandom_range(0, 3))
			0: return 10'($urandom_range(0, 7));
			1: return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	// Sorted insert after every equal or earlier day; dequeue takes the head.
	function automatic void apply_queue_request(input sepq_req_t r);
		sepq_rsp_t   want;
		held_event_t e;
		int          pos;
		want = '0;
		if (r.op == OP_ENQ) begin
			if (held_events.size() >= QUEUE_DEPTH) begin
				want.status = ST_FULL;
			end else begin
				e.day = r.event_day;
				e.kind = r.event_kind;
				pos = 0;
				while (pos < held_events.size() && held_events[pos].day <= e.day)
					pos++;
				held_events.insert(pos, e);
				want.status = ST_OK;
			end
		end else begin
			if (held_events.size() == 0) begin
				want.status = ST_EMPTY;
			end else begin
				e = held_events.pop_front();
				want.status = ST_OK;
				want.popped_day = e.day;
				want.popped_kind = e.kind;
			end
		end
		want.occupancy = 5'(held_events.size());
		responses_due.push_back(want);
	endfunction

	function automatic void check_response(input sepq_rsp_t got);
		sepq_rsp_t want;
		bit        none_due;
		bit        bad;
		none_due = (responses_due.size() == 0);
		want = none_due ? '0 : responses_due.pop_front();
		bad = none_due || (got.status !== want.status) || (got.popped_day !== want.popped_day)
			|| (got.popped_kind !== want.popped_kind) || (got.occupancy !== want.occupancy);
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$write("%0t: response %0d mismatch%s: expected st=%0d day=%0d kind=%0d occ=%0d",
					$realtime, rsp_seen, none_due ? " (none due)" : "",
					want.status, want.popped_day, want.popped_kind, want.occupancy);
				$display(", got st=%0d day=%0d kind=%0d occ=%0d",
					got.status, got.popped_day, got.popped_kind, got.occupancy);
			end
		end
	endfunction

	// Request driver: hold until accepted, idle in bursts outside the calm tail.
	always @(negedge clk) begin
		if ($urandom_range(0, 39) == 0)
			req_idle_level <= $urandom_range(0, 3);
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_done == req_sent) begin
			if (req_gap > 0) begin
				req_gap <= req_gap - 1;
				req_valid <= 1'b0;
			end else if (request_backlog.size() == 0) begin
				req_valid <= 1'b0;
			end else if (req_idle_level != 0 && req_sent + CALM_TAIL < req_total
					&& $urandom_range(0, 4 * req_idle_level - 1) == 0) begin
				req_gap <= $urandom_range(0, 13);
				req_valid <= 1'b0;
			end else begin
				req <= request_backlog.pop_front();
				req_valid <= 1'b1;
				req_sent <= req_sent + 1;
			end
		end
	end

	// Response stall driver.
	always @(negedge clk) begin
		if ($urandom_range(0, 39) == 0)
			rsp_idle_level <= $urandom_range(0, 3);
		if (rsp_gap > 0) begin
			rsp_gap <= rsp_gap - 1;
			rsp_ready <= 1'b0;
		end else if (rsp_idle_level != 0 && rsp_seen + CALM_TAIL < req_total
				&& $urandom_range(0, 4 * rsp_idle_level - 1) == 0) begin
			rsp_gap <= $urandom_range(0, 13);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Monitor: predict on request handshake, check on response handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				apply_queue_request(req);
				req_done <= req_done + 1;
			end
			if (rsp_valid && rsp_ready) begin
				check_response(rsp);
				rsp_seen <= rsp_seen + 1;
			end
		end
	end

	initial begin
		int unsigned n;
		int unsigned seg_len;
		int unsigned enq_pct;
		// Directed: empty dequeue, extremes, insert before head, equal-day order, drain.
		push_dequeue();
		push_enqueue(10'd500, 1'b0);
		push_enqueue(10'd1023, 1'b1);
		push_enqueue(10'd0, 1'b1);
		push_enqueue(10'd500, 1'b1);
		push_enqueue(10'd0, 1'b0);
		push_enqueue(10'd1023, 1'b0);
		push_enqueue(10'd341, 1'b1);
		push_enqueue(10'd682, 1'b0);
		repeat (8) push_dequeue();
		push_dequeue();
		// Random: segments leaning toward fill, drain or balance.
		n = 0;
		while (n < 650) begin
			seg_len = $urandom_range(8, 40);
			case ($urandom_range(0, 2))
				0: enq_pct = 85;
				1: enq_pct = 15;
				default: enq_pct = 50;
			endcase
			repeat (seg_len) begin
				if ($urandom_range(1, 100) <= enq_pct)
					push_enqueue(pick_day(), 1'($urandom_range(0, 1)));
				else
					push_dequeue();
			end
			n += seg_len;
		end
		req_total = request_backlog.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_done != req_total || responses_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_event_priority_queue_unit verification clean");
		else
			$display("sorted_event_priority_queue_unit verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("sorted_event_priority_queue_unit verification failed");
		$finish;
	end

endmodule
